### sv/lfps_pkg.sv
// Shared constants for the LFSR fizzle pixel sequencer.
// Register indexes, register reset values and field widths.
// No dependencies.
package lfps_pkg;

   // field widths
   localparam int TAP_W   = 25;
   localparam int YB_W    = 4;
   localparam int COORD_W = 12;
   localparam int ADDR_W  = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   // default parameter values
   localparam int SCREEN_STRIDE_DEF = 320;
   localparam int LFSR_WIDTH_DEF    = 25;

   // widest row field the LFSR can hold (y_bits is at most 15)
   localparam int Y_W = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_MASK      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_BITS        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y      = 3'd5;

   // register reset values
   localparam logic [TAP_W-1:0]   TAP_MASK_RST      = 25'h0012000;
   localparam logic [YB_W-1:0]    Y_BITS_RST        = 4'd8;
   localparam logic [COORD_W-1:0] REGION_WIDTH_RST  = 12'd320;
   localparam logic [COORD_W-1:0] REGION_HEIGHT_RST = 12'd200;
   localparam logic [COORD_W-1:0] ORIGIN_X_RST      = 12'd0;
   localparam logic [COORD_W-1:0] ORIGIN_Y_RST      = 12'd0;

endpackage

### sv/lfsr_fizzle_pixel_sequencer.sv
// Top level of the LFSR fizzle pixel sequencer.
// Depends on lfps_pkg for register indexes, reset values and widths.
//
// Every accepted request word advances a Galois LFSR by one step and gives
// exactly one response word: the pixel named by the current LFSR value when
// it lies inside the configured region, and the finished flag. The block
// takes one request word per clock unless the response side stalls, and
// answers via stage 1 and result registers, paced by the LFSR step. The first
// stage splits the value into column and row, checks the region and forms the
// row and column sums; the second multiplies the row by the screen stride and
// adds the column. Stall on the response side backs up through both stages.
// A restart bit in a word clears the LFSR and the finished flag before that
// step. Once finished, words give no pixel and the LFSR holds until restart.
module lfsr_fizzle_pixel_sequencer
   import lfps_pkg::*;
#(
   parameter int SCREEN_STRIDE = SCREEN_STRIDE_DEF,
   parameter int LFSR_WIDTH    = LFSR_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_restart,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pixel_valid,
   output logic [COORD_W-1:0]    rsp_pixel_x,
   output logic [COORD_W-1:0]    rsp_pixel_y,
   output logic [ADDR_W-1:0]     rsp_pixel_address,
   output logic                  rsp_finished
);

   localparam int STRIDE_W = $clog2(SCREEN_STRIDE + 1);
   localparam int ROW_W    = COORD_W + 1;
   localparam int PROD_W   = ROW_W + STRIDE_W;
   localparam logic [STRIDE_W-1:0] STRIDE_C = STRIDE_W'(SCREEN_STRIDE);

   // configuration registers
   logic [TAP_W-1:0]   tap_mask_ff;
   logic [YB_W-1:0]    y_bits_ff;
   logic [COORD_W-1:0] region_width_ff;
   logic [COORD_W-1:0] region_height_ff;
   logic [COORD_W-1:0] origin_x_ff;
   logic [COORD_W-1:0] origin_y_ff;

   // sequencer state
   logic [LFSR_WIDTH-1:0] lfsr_ff, lfsr_in;
   logic                  done_ff, done_in;

   // stage 1 registers
   logic               s1_valid_ff;
   logic               s1_pix_ff, s1_pix_in;
   logic               s1_fin_ff, s1_fin_in;
   logic [COORD_W-1:0] s1_x_ff, s1_x_in;
   logic [COORD_W-1:0] s1_y_ff, s1_y_in;
   logic [ROW_W-1:0]   s1_row_ff, s1_row_in;
   logic [ROW_W-1:0]   s1_col_ff, s1_col_in;

   // result registers
   logic               rsp_valid_ff;
   logic               rsp_pix_ff;
   logic               rsp_fin_ff;
   logic [COORD_W-1:0] rsp_x_ff;
   logic [COORD_W-1:0] rsp_y_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;

   logic out_en, s1_en, accept;

   logic [LFSR_WIDTH-1:0] cur, next, x_full;
   logic [Y_W-1:0]        y_mask, y_full;
   logic                  done_eff, in_region;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W:0]       addr_full;

   // pipeline flow control
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s1_en     = !s1_valid_ff || out_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_mask_ff      <= TAP_MASK_RST;
         y_bits_ff        <= Y_BITS_RST;
         region_width_ff  <= REGION_WIDTH_RST;
         region_height_ff <= REGION_HEIGHT_RST;
         origin_x_ff      <= ORIGIN_X_RST;
         origin_y_ff      <= ORIGIN_Y_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_MASK:      tap_mask_ff      <= csr_data[TAP_W-1:0];
            CSR_Y_BITS:        y_bits_ff        <= csr_data[YB_W-1:0];
            CSR_REGION_WIDTH:  region_width_ff  <= csr_data[COORD_W-1:0];
            CSR_REGION_HEIGHT: region_height_ff <= csr_data[COORD_W-1:0];
            CSR_ORIGIN_X:      origin_x_ff      <= csr_data[COORD_W-1:0];
            CSR_ORIGIN_Y:      origin_y_ff      <= csr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // step the LFSR and split the current value into column and row
   always_comb begin
      cur      = req_restart ? '0 : lfsr_ff;
      done_eff = req_restart ? 1'b0 : done_ff;

      next = (cur >> 1) ^ (cur[0] ? '0 : tap_mask_ff[LFSR_WIDTH-1:0]);

      x_full    = cur >> y_bits_ff;
      y_mask    = ~({Y_W{1'b1}} << y_bits_ff);
      y_full    = cur[Y_W-1:0] & y_mask;
      in_region = (x_full < LFSR_WIDTH'(region_width_ff)) &&
                  (y_full < Y_W'(region_height_ff));

      lfsr_in   = lfsr_ff;
      done_in   = done_eff;
      s1_pix_in = 1'b0;
      s1_fin_in = 1'b1;
      if (!done_eff) begin
         lfsr_in   = next;
         done_in   = (next == '0);
         s1_pix_in = in_region;
         s1_fin_in = (next == '0);
      end

      // inside the region both coordinates fit in 12 bits
      s1_x_in   = s1_pix_in ? x_full[COORD_W-1:0] : '0;
      s1_y_in   = s1_pix_in ? y_full[COORD_W-1:0] : '0;
      s1_row_in = ROW_W'(origin_y_ff) + ROW_W'(s1_y_in);
      s1_col_in = ROW_W'(origin_x_ff) + ROW_W'(s1_x_in);
   end

   // hold LFSR state; advance on each accepted word until finished
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= '0;
         done_ff <= 1'b0;
      end else if (accept) begin
         lfsr_ff <= lfsr_in;
         done_ff <= done_in;
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= s1_pix_in;
         s1_fin_ff <= s1_fin_in;
         s1_x_ff   <= s1_x_in;
         s1_y_ff   <= s1_y_in;
         s1_row_ff <= s1_row_in;
         s1_col_ff <= s1_col_in;
      end
   end

   // address: row times stride plus column, wrapped to the address width
   always_comb begin
      prod        = PROD_W'(s1_row_ff) * PROD_W'(STRIDE_C);
      addr_full   = (PROD_W + 1)'(prod) + (PROD_W + 1)'(s1_col_ff);
      rsp_addr_in = s1_pix_ff ? ADDR_W'(addr_full) : '0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         rsp_pix_ff  <= s1_pix_ff;
         rsp_fin_ff  <= s1_fin_ff;
         rsp_x_ff    <= s1_x_ff;
         rsp_y_ff    <= s1_y_ff;
         rsp_addr_ff <= rsp_addr_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_valid   = rsp_pix_ff;
   assign rsp_pixel_x       = rsp_x_ff;
   assign rsp_pixel_y       = rsp_y_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_finished      = rsp_fin_ff;

   // finished state only ever sits on an all-zero LFSR
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (lfsr_ff == '0))
      else $error("finished flag set with nonzero LFSR");

   // a word without a pixel carries zero coordinates and address
   a_no_pix_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pix_ff) |->
         (rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_addr_ff == '0))
      else $error("pixel fields nonzero without a pixel");

   // request side stalls only when both stages are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // a delivered pixel lies inside the region
   a_pix_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pix_ff) |->
         (rsp_x_ff < region_width_ff && rsp_y_ff < region_height_ff))
      else $error("pixel outside the region");

endmodule
